[hw/rtl/bdm_pkg.sv]
package bdm_pkg;

   typedef enum logic [2:0] {
      PH_IDLE         = 3'd0,
      PH_SINGLE_HELD  = 3'd1,
      PH_FIRST_PRESS  = 3'd2,
      PH_ONE_RELEASED = 3'd3,
      PH_DOUBLE_HELD  = 3'd4,
      PH_SECOND_PRESS = 3'd5,
      PH_TWO_RELEASED = 3'd6,
      PH_TRIPLE_HELD  = 3'd7
   } phase_type;

   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 16;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_DEBOUNCE   = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_INTERCLICK = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_REPEAT_EN  = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DOUBLE_EN  = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_TRIPLE_EN  = 3'd4;

   localparam logic [7:0]  DEBOUNCE_RESET   = 8'd20;
   localparam logic [15:0] INTERCLICK_RESET = 16'd500;

   localparam logic [1:0] EVT_NONE   = 2'd0;
   localparam logic [1:0] EVT_SINGLE = 2'd1;
   localparam logic [1:0] EVT_DOUBLE = 2'd2;
   localparam logic [1:0] EVT_TRIPLE = 2'd3;

   localparam logic [14:0] REP_HELD_1 = 15'd1000;
   localparam logic [14:0] REP_HELD_2 = 15'd3000;
   localparam logic [14:0] REP_HELD_3 = 15'd7000;
   localparam logic [14:0] REP_HELD_4 = 15'd12000;
   localparam logic [14:0] REP_HELD_5 = 15'd18000;

   localparam logic [9:0] REP_GAP_1 = 10'd1000;
   localparam logic [9:0] REP_GAP_2 = 10'd500;
   localparam logic [9:0] REP_GAP_3 = 10'd250;
   localparam logic [9:0] REP_GAP_4 = 10'd100;
   localparam logic [9:0] REP_GAP_5 = 10'd50;
   localparam logic [9:0] REP_GAP_6 = 10'd25;

endpackage

[hw/rtl/button_debounce_multiclick.sv]
// The result of an accepted request is registered and shown in the cycle after it is accepted.
// Throughput: one request per cycle unless stalled; all work is one pass of logic into the result register.
// The request side stalls only while a finished result waits and the result side stalls.
// Reset is synchronous and active high: level released, click machine idle, click and
// repeat timers saturated, registers at debounce 20 ms and inter-click 500 ms.
module button_debounce_multiclick #(
   parameter int TIMER_BITS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_raw_level,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [1:0]                          rsp_click_event,
   output logic                                rsp_is_pressed,
   output logic                                rsp_level_changed,
   input  logic                                csr_write,
   input  logic [bdm_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [bdm_pkg::CSR_DATA_BITS-1:0]   csr_wdata
);
   import bdm_pkg::*;

   localparam int CW = (TIMER_BITS > 16) ? TIMER_BITS : 16;
   localparam logic [TIMER_BITS-1:0] TMAX = '1;

   logic [7:0]            debounce_ff;
   logic [15:0]           interclick_ff;
   logic                  repeat_en_ff;
   logic                  double_en_ff;
   logic                  triple_en_ff;

   logic                  released_ff, released_in;
   logic [TIMER_BITS-1:0] since_change_ff, since_change_in;
   logic [TIMER_BITS-1:0] since_click_ff, since_click_in;
   logic [TIMER_BITS-1:0] since_action_ff, since_action_in;
   phase_type             phase_ff, phase_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [1:0]            event_ff;
   logic                  pressed_ff;
   logic                  changed_ff;

   logic                  accept;
   logic [TIMER_BITS-1:0] change_up, click_up, action_up;
   logic                  changed;
   logic                  just_pressed;
   logic                  timed_out;
   logic [9:0]            gap;
   logic                  repeat_due;
   logic [1:0]            action;
   logic                  clear_click;

   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;

   assign change_up = (since_change_ff == TMAX) ? since_change_ff : since_change_ff + 1'b1;
   assign click_up  = (since_click_ff == TMAX)  ? since_click_ff  : since_click_ff + 1'b1;
   assign action_up = (since_action_ff == TMAX) ? since_action_ff : since_action_ff + 1'b1;

   assign changed = (req_raw_level != released_ff) &&
                    ((CW'(change_up) >= CW'(debounce_ff)) || (change_up == TMAX));
   assign released_in     = changed ? req_raw_level : released_ff;
   assign since_change_in = changed ? '0 : change_up;
   assign just_pressed    = changed & ~released_in;
   assign timed_out = (CW'(click_up) >= CW'(interclick_ff)) || (click_up == TMAX);

   always_comb begin
      if (CW'(since_change_in) < CW'(REP_HELD_1)) begin
         gap = REP_GAP_1;
      end else if (CW'(since_change_in) < CW'(REP_HELD_2)) begin
         gap = REP_GAP_2;
      end else if (CW'(since_change_in) < CW'(REP_HELD_3)) begin
         gap = REP_GAP_3;
      end else if (CW'(since_change_in) < CW'(REP_HELD_4)) begin
         gap = REP_GAP_4;
      end else if (CW'(since_change_in) < CW'(REP_HELD_5)) begin
         gap = REP_GAP_5;
      end else begin
         gap = REP_GAP_6;
      end
   end

   assign repeat_due = repeat_en_ff &&
                       ((CW'(action_up) >= CW'(gap)) || (action_up == TMAX));

   // Next phase of the click machine.
   always_comb begin
      phase_in = phase_ff;
      unique case (phase_ff)
         PH_IDLE: begin
            if (just_pressed) begin
               phase_in = (!triple_en_ff && !double_en_ff) ? PH_SINGLE_HELD : PH_FIRST_PRESS;
            end
         end
         PH_ONE_RELEASED: begin
            if (just_pressed) begin
               phase_in = !triple_en_ff ? PH_DOUBLE_HELD : PH_SECOND_PRESS;
            end else if (timed_out) begin
               phase_in = PH_IDLE;
            end
         end
         PH_TWO_RELEASED: begin
            if (just_pressed) begin
               phase_in = PH_TRIPLE_HELD;
            end else if (timed_out) begin
               phase_in = PH_IDLE;
            end
         end
         PH_SINGLE_HELD, PH_DOUBLE_HELD, PH_TRIPLE_HELD: begin
            if (released_in) begin
               phase_in = PH_IDLE;
            end
         end
         PH_FIRST_PRESS: begin
            if (released_in) begin
               phase_in = PH_ONE_RELEASED;
            end else if (timed_out) begin
               phase_in = PH_SINGLE_HELD;
            end
         end
         PH_SECOND_PRESS: begin
            if (released_in) begin
               phase_in = PH_TWO_RELEASED;
            end else if (timed_out) begin
               phase_in = PH_DOUBLE_HELD;
            end
         end
         default: phase_in = PH_IDLE;
      endcase
   end

   // Click events and timer clears of the click machine.
   always_comb begin
      action      = EVT_NONE;
      clear_click = 1'b0;
      unique case (phase_ff)
         PH_IDLE: begin
            if (just_pressed) begin
               if (!triple_en_ff && !double_en_ff) begin
                  action = EVT_SINGLE;
               end else begin
                  clear_click = 1'b1;
               end
            end
         end
         PH_ONE_RELEASED: begin
            if (just_pressed) begin
               if (!triple_en_ff) begin
                  action = EVT_DOUBLE;
               end else begin
                  clear_click = 1'b1;
               end
            end else if (timed_out) begin
               action = EVT_SINGLE;
            end
         end
         PH_TWO_RELEASED: begin
            if (just_pressed) begin
               action = EVT_TRIPLE;
            end else if (timed_out) begin
               action = EVT_DOUBLE;
            end
         end
         PH_SINGLE_HELD: begin
            if (!released_in && repeat_due) begin
               action = EVT_SINGLE;
            end
         end
         PH_DOUBLE_HELD: begin
            if (!released_in && repeat_due) begin
               action = EVT_DOUBLE;
            end
         end
         PH_TRIPLE_HELD: begin
            if (!released_in && repeat_due) begin
               action = EVT_TRIPLE;
            end
         end
         PH_FIRST_PRESS: begin
            if (!released_in && timed_out) begin
               action = EVT_SINGLE;
            end
         end
         PH_SECOND_PRESS: begin
            if (!released_in && timed_out) begin
               action = EVT_DOUBLE;
            end
         end
         default: action = EVT_NONE;
      endcase
   end

   assign since_click_in  = clear_click ? '0 : click_up;
   assign since_action_in = (action != EVT_NONE) ? '0 : action_up;
   assign rsp_valid_in    = accept | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff   <= DEBOUNCE_RESET;
         interclick_ff <= INTERCLICK_RESET;
         repeat_en_ff  <= 1'b0;
         double_en_ff  <= 1'b0;
         triple_en_ff  <= 1'b0;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_DEBOUNCE:   debounce_ff   <= csr_wdata[7:0];
            CSR_INTERCLICK: interclick_ff <= csr_wdata[15:0];
            CSR_REPEAT_EN:  repeat_en_ff  <= csr_wdata[0];
            CSR_DOUBLE_EN:  double_en_ff  <= csr_wdata[0];
            CSR_TRIPLE_EN:  triple_en_ff  <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         released_ff     <= 1'b1;
         since_change_ff <= '0;
         since_click_ff  <= '1;
         since_action_ff <= '1;
         phase_ff        <= PH_IDLE;
         rsp_valid_ff    <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            released_ff     <= released_in;
            since_change_ff <= since_change_in;
            since_click_ff  <= since_click_in;
            since_action_ff <= since_action_in;
            phase_ff        <= phase_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         event_ff   <= action;
         pressed_ff <= ~released_in;
         changed_ff <= changed;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_click_event   = event_ff;
   assign rsp_is_pressed    = pressed_ff;
   assign rsp_level_changed = changed_ff;

`ifndef SYNTHESIS
   assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid_ff)
      else $error("Accepted request produced no result.");

   assert property (@(posedge clock) disable iff (reset)
      released_ff == (phase_ff == PH_IDLE || phase_ff == PH_ONE_RELEASED ||
                      phase_ff == PH_TWO_RELEASED))
      else $error("Click phase disagrees with the debounced level.");

   assert property (@(posedge clock) disable iff (reset)
      (accept && action != EVT_NONE) |=> (since_action_ff == '0))
      else $error("Emitted click did not restart the repeat timer.");

   assert property (@(posedge clock) disable iff (reset)
      (accept && changed) |=> (since_change_ff == '0 && rsp_level_changed))
      else $error("Accepted level change not recorded.");
`endif

endmodule
